// ===== src/gifs_pkg.sv =====
// ----------------------------------------------------------------------------
// gifs_pkg
// shared types, constants and the prefix table of the gps info field splitter
// ----------------------------------------------------------------------------
package gifs_pkg;

	// default sizing
	localparam int MAX_LEN_DEF     = 1024;
	localparam int FIELD_COUNT_DEF = 9;

	// fixed port and counter widths
	localparam int FLD_W   = 4;
	localparam int OFS_W   = 10;
	localparam int MATCH_W = 4;

	// prefix "+CGPSINFO:"
	localparam logic [MATCH_W-1:0] PREFIX_LEN = MATCH_W'(10);

	// characters of interest
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// status codes
	localparam logic ST_OK        = 1'b0;
	localparam logic ST_NOT_FOUND = 1'b1;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_SKIP,
		PH_FIELDS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [FLD_W-1:0] field_number;
		logic [OFS_W-1:0] start_offset;
		logic [OFS_W-1:0] field_length;
		logic             present;
		logic             status;
		logic             last;
	} result_t;

	function automatic logic [7:0] prefix_char(input logic [MATCH_W-1:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0:    ch = 8'h2B; // +
			4'd1:    ch = 8'h43; // C
			4'd2:    ch = 8'h47; // G
			4'd3:    ch = 8'h50; // P
			4'd4:    ch = 8'h53; // S
			4'd5:    ch = 8'h49; // I
			4'd6:    ch = 8'h4E; // N
			4'd7:    ch = 8'h46; // F
			4'd8:    ch = 8'h4F; // O
			4'd9:    ch = 8'h3A; // :
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== src/gps_info_field_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// gps_info_field_splitter_unit
// splits a "+CGPSINFO:" modem response into nine comma separated fields
// ----------------------------------------------------------------------------
//
// channel  dir  handshake             beat payload
// -------  ---  --------------------  ------------------------------------------
// in       in   in_valid / in_ready   char_code, end_mark
// out      out  out_valid / out_ready field_number, start_offset, field_length,
//                                     present, status, last
//
// one character beat a cycle unless a stall holds it: input register, single
// pass of parse logic, result register, in that order from accept to result
// an end-of-string beat drains one result a cycle while the buffer has room,
// holding the input until the last field is out (one result if no prefix)
// arst_n clears the input stage, the parse state and the result buffer
// a stalled out channel fills one skid entry, then in_ready drops; in_ready
// depends only on registered state
//
module gps_info_field_splitter_unit import gifs_pkg::*; #(
	parameter int MAX_LEN     = MAX_LEN_DEF,
	parameter int FIELD_COUNT = FIELD_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// character beats
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       char_code,
	input  logic             end_mark,
	// field result beats
	output logic             out_valid,
	input  logic             out_ready,
	output logic [FLD_W-1:0] field_number,
	output logic [OFS_W-1:0] start_offset,
	output logic [OFS_W-1:0] field_length,
	output logic             present,
	output logic             status,
	output logic             last
);

	// parser to result buffer
	logic    res_push;
	logic    res_full;
	result_t res_data;
	result_t out_data;

	gifs_parse #(
		.MAX_LEN     (MAX_LEN),
		.FIELD_COUNT (FIELD_COUNT)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.end_mark  (end_mark),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// result register plus skid entry
	gifs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.din       (res_data),
		.full      (res_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dout      (out_data)
	);

	// unpack the result beat onto its ports
	assign field_number = out_data.field_number;
	assign start_offset = out_data.start_offset;
	assign field_length = out_data.field_length;
	assign present      = out_data.present;
	assign status       = out_data.status;
	assign last         = out_data.last;

endmodule

// ===== src/gifs_parse.sv =====
// ----------------------------------------------------------------------------
// gifs_parse
// input register, prefix match, field split and end-of-string drain
// ----------------------------------------------------------------------------
module gifs_parse import gifs_pkg::*; #(
	parameter int MAX_LEN     = MAX_LEN_DEF,
	parameter int FIELD_COUNT = FIELD_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       end_mark,
	input  logic       res_full,
	output logic       res_push,
	output result_t    res_data
);

	localparam int PW = $clog2(MAX_LEN);
	localparam logic [PW-1:0]    POS_MAX    = PW'(MAX_LEN - 1);
	localparam logic [FLD_W-1:0] FIELD_LAST = FLD_W'(FIELD_COUNT - 1);

	// input stage
	logic       v_s1;
	logic [7:0] char_s1;
	logic       end_s1;

	// parser state
	phase_t             phase_q, phase_n;
	logic [MATCH_W-1:0] match_q, match_n;
	logic [PW-1:0]      pos_q, pos_n;
	logic [FLD_W-1:0]   field_q, field_n;
	logic [PW-1:0]      begin_q, begin_n;
	logic [PW-1:0]      run_q, run_n;

	logic          need_push;
	logic          final_emit;
	logic          commit;
	logic          take;
	logic          is_last_fld;
	logic [PW-1:0] begin_v;
	logic [PW-1:0] run_v;
	result_t       res;

	function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
		return (v >= POS_MAX) ? POS_MAX : v + 1'b1;
	endfunction

	function automatic logic [OFS_W-1:0] to_ofs(input logic [PW-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[OFS_W-1:0];
	endfunction

	function automatic result_t make_res(input logic [FLD_W-1:0] fld,
		input logic [PW-1:0] bgn, input logic [PW-1:0] len,
		input logic lst);
		result_t r;
		r.field_number = fld;
		r.start_offset = (len != '0) ? to_ofs(bgn) : '0;
		r.field_length = to_ofs(len);
		r.present      = (len != '0);
		r.status       = ST_OK;
		r.last         = lst;
		return r;
	endfunction

	assign is_last_fld = (field_q == FIELD_LAST);

	always_comb begin
		phase_n    = phase_q;
		match_n    = match_q;
		pos_n      = pos_q;
		field_n    = field_q;
		begin_n    = begin_q;
		run_n      = run_q;
		need_push  = 1'b0;
		final_emit = 1'b0;
		res        = '0;
		begin_v    = begin_q;
		run_v      = run_q;
		if (end_s1) begin
			need_push = 1'b1;
			if (phase_q == PH_SEARCH) begin
				final_emit   = 1'b1;
				res.status   = ST_NOT_FOUND;
				res.last     = 1'b1;
			end else begin
				// one field per cycle while the result buffer has room, the open one first
				run_v      = (phase_q == PH_SKIP) ? '0 : run_q;
				final_emit = is_last_fld;
				res        = make_res(field_q, begin_q, run_v, is_last_fld);
				phase_n    = PH_FIELDS;
				field_n    = field_q + 1'b1;
				begin_n    = '0;
				run_n      = '0;
			end
			if (final_emit) begin
				phase_n = PH_SEARCH;
				match_n = '0;
				pos_n   = '0;
				field_n = '0;
				begin_n = '0;
				run_n   = '0;
			end
		end else begin
			pos_n = sat_inc(pos_q);
			case (phase_q)
				PH_SEARCH: begin
					if (match_q < PREFIX_LEN && char_s1 == prefix_char(match_q)) begin
						match_n = match_q + 1'b1;
						if (match_n == PREFIX_LEN)
							phase_n = PH_SKIP;
					end else begin
						match_n = (char_s1 == CH_PLUS) ? MATCH_W'(1) : '0;
					end
				end
				PH_SKIP, PH_FIELDS: begin
					// first non-space opens field zero at this offset
					begin_v = (phase_q == PH_SKIP) ? pos_q : begin_q;
					run_v   = (phase_q == PH_SKIP) ? '0 : run_q;
					if (phase_q == PH_FIELDS || char_s1 != CH_SPACE) begin
						phase_n = PH_FIELDS;
						begin_n = begin_v;
						run_n   = run_v;
						if (char_s1 == CH_COMMA) begin
							if (is_last_fld) begin
								// final field frozen until end of string
								phase_n = PH_DONE;
							end else begin
								need_push = 1'b1;
								res       = make_res(field_q, begin_v, run_v, 1'b0);
								field_n   = field_q + 1'b1;
								begin_n   = sat_inc(pos_q);
								run_n     = '0;
							end
						end else begin
							run_n = sat_inc(run_v);
						end
					end
				end
				PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign commit   = v_s1 && !(need_push && res_full);
	assign take     = commit && (!end_s1 || final_emit);
	assign in_ready = !v_s1 || take;
	assign res_push = v_s1 && need_push && !res_full;
	assign res_data = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			end_s1  <= end_mark;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			match_q <= '0;
			pos_q   <= '0;
			field_q <= '0;
			begin_q <= '0;
			run_q   <= '0;
		end else if (commit) begin
			phase_q <= phase_n;
			match_q <= match_n;
			pos_q   <= pos_n;
			field_q <= field_n;
			begin_q <= begin_n;
			run_q   <= run_n;
		end
	end

	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		field_q <= FIELD_LAST)
		else $error("field index beyond last field");

	a_match_range: assert property (@(posedge clk) disable iff (!arst_n)
		match_q <= PREFIX_LEN)
		else $error("prefix match count out of range");

	a_prefix_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_SEARCH |-> match_q == PREFIX_LEN)
		else $error("left search without a full prefix match");

	a_last_consumes: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_data.last |-> take && end_s1)
		else $error("last result without consuming the end beat");

endmodule

// ===== src/gifs_out_buf.sv =====
// ----------------------------------------------------------------------------
// gifs_out_buf
// result register with one skid entry
// ----------------------------------------------------------------------------
module gifs_out_buf import gifs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    full,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t dout
);

	logic    out_v_q;
	result_t out_d_q;
	logic    spare_v_q;
	result_t spare_d_q;
	logic    slot_free;

	assign slot_free = !out_v_q || out_ready;
	assign full      = spare_v_q;
	assign out_valid = out_v_q;
	assign dout      = out_d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			spare_v_q <= 1'b0;
		end else if (slot_free) begin
			if (spare_v_q) begin
				out_v_q   <= 1'b1;
				spare_v_q <= 1'b0;
			end else begin
				out_v_q   <= push;
			end
		end else if (push) begin
			spare_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (spare_v_q)
				out_d_q <= spare_d_q;
			else if (push)
				out_d_q <= din;
		end else if (push) begin
			spare_d_q <= din;
		end
	end

	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		spare_v_q |-> out_v_q)
		else $error("skid entry held with empty output register");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !spare_v_q)
		else $error("push into full result buffer");

	a_stall_fills_spare: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ready && push |=> spare_v_q && out_v_q)
		else $error("stalled push lost");

endmodule

// ===== bench/gifs_field_checker.sv =====
// ----------------------------------------------------------------------------
// gifs_field_checker
// follows the character beats taken by the splitter, works out the field
// results they must produce and compares each result beat against the oldest
// one still owed
// ----------------------------------------------------------------------------
module gifs_field_checker import gifs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [7:0]       char_code,
	input  logic             end_mark,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [FLD_W-1:0] field_number,
	input  logic [OFS_W-1:0] start_offset,
	input  logic [OFS_W-1:0] field_length,
	input  logic             present,
	input  logic             status,
	input  logic             last,
	output int unsigned      mismatches,
	output int unsigned      fields_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                   NUM_FIELDS  = FIELD_COUNT_DEF;
	localparam logic [OFS_W-1:0]     OFS_CAP     = OFS_W'(MAX_LEN_DEF - 1);
	localparam int                   TAG_LEN     = 10;
	localparam logic [8*TAG_LEN-1:0] GPS_TAG     = "+CGPSINFO:";
	localparam int                   MAX_REPORTS = 40;

	phase_t             scan_phase;
	logic [MATCH_W-1:0] tag_matched;
	logic [OFS_W-1:0]   char_pos;
	logic [FLD_W-1:0]   field_idx;
	logic [OFS_W-1:0]   field_start;
	logic [OFS_W-1:0]   chars_in_field;
	result_t            field_q[$];

	function automatic logic [7:0] tag_char(input logic [MATCH_W-1:0] idx);
		return GPS_TAG[8*(TAG_LEN - 1 - int'(idx)) +: 8];
	endfunction

	function automatic logic [OFS_W-1:0] bump(input logic [OFS_W-1:0] v);
		return (v >= OFS_CAP) ? OFS_CAP : v + 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		// keep the log short on a badly broken block, count everything
		if (mismatches < MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic clear_scan();
		scan_phase     = PH_SEARCH;
		tag_matched    = '0;
		char_pos       = '0;
		field_idx      = '0;
		field_start    = '0;
		chars_in_field = '0;
	endtask

	task automatic push_field(input int fld, input logic [OFS_W-1:0] beg,
			input logic [OFS_W-1:0] len, input logic st, input logic fin);
		result_t r;
		r.field_number = FLD_W'(fld);
		r.start_offset = (len != '0) ? beg : '0;
		r.field_length = len;
		r.present      = (len != '0);
		r.status       = st;
		r.last         = fin;
		field_q.push_back(r);
	endtask

	// end of string: close the open field, the rest follow empty; not found if no prefix
	task automatic close_string();
		logic [OFS_W-1:0] len;
		logic [OFS_W-1:0] beg;
		int               f;
		if (scan_phase == PH_SEARCH) begin
			push_field(0, '0, '0, ST_NOT_FOUND, 1'b1);
		end else begin
			len = (scan_phase == PH_SKIP) ? '0 : chars_in_field;
			beg = field_start;
			for (f = int'(field_idx); f < NUM_FIELDS; f++) begin
				push_field(f, beg, len, ST_OK, f == NUM_FIELDS - 1);
				len = '0;
				beg = '0;
			end
		end
		clear_scan();
	endtask

	task automatic take_field_char(input logic [7:0] ch, input logic [OFS_W-1:0] here);
		if (ch != CH_COMMA) begin
			chars_in_field = bump(chars_in_field);
		end else if (int'(field_idx) + 1 >= NUM_FIELDS) begin
			// comma behind the final field freezes it until end of string
			scan_phase = PH_DONE;
		end else begin
			push_field(int'(field_idx), field_start, chars_in_field, ST_OK, 1'b0);
			field_idx      = field_idx + 1'b1;
			field_start    = bump(here);
			chars_in_field = '0;
		end
	endtask

	task automatic predict_beat(input logic [7:0] ch, input logic em);
		logic [OFS_W-1:0] here;
		here = char_pos;
		if (em) begin
			close_string();
		end else begin
			char_pos = bump(char_pos);
			case (scan_phase)
				PH_SEARCH: begin
					if (int'(tag_matched) < TAG_LEN && ch == tag_char(tag_matched)) begin
						tag_matched = tag_matched + 1'b1;
						if (int'(tag_matched) >= TAG_LEN)
							scan_phase = PH_SKIP;
					end else begin
						tag_matched = (ch == CH_PLUS) ? MATCH_W'(1) : '0;
					end
				end
				PH_SKIP: begin
					if (ch != CH_SPACE) begin
						scan_phase     = PH_FIELDS;
						field_start    = here;
						chars_in_field = '0;
						take_field_char(ch, here);
					end
				end
				PH_FIELDS: take_field_char(ch, here);
				default: ;
			endcase
		end
	endtask

	task automatic check_result();
		result_t want;
		if (field_q.size() == 0) begin
			report_mismatch($sformatf("result beat for field %0d with none owed", field_number));
		end else begin
			want = field_q.pop_front();
			if (field_number !== want.field_number)
				report_mismatch($sformatf("field_number exp %0d got %0d",
					want.field_number, field_number));
			if (start_offset !== want.start_offset)
				report_mismatch($sformatf("field %0d start_offset exp %0d got %0d",
					want.field_number, want.start_offset, start_offset));
			if (field_length !== want.field_length)
				report_mismatch($sformatf("field %0d field_length exp %0d got %0d",
					want.field_number, want.field_length, field_length));
			if (present !== want.present)
				report_mismatch($sformatf("field %0d present exp %0b got %0b",
					want.field_number, want.present, present));
			if (status !== want.status)
				report_mismatch($sformatf("field %0d status exp %0b got %0b",
					want.field_number, want.status, status));
			if (last !== want.last)
				report_mismatch($sformatf("field %0d last exp %0b got %0b",
					want.field_number, want.last, last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			field_q.delete();
			mismatches = 0;
			fields_pending <= 0;
		end else begin
			// a result never stems from a beat taken at the same edge
			if (out_valid && out_ready)
				check_result();
			if (in_valid && in_ready)
				predict_beat(char_code, end_mark);
			fields_pending <= field_q.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives modem response strings into the gps info field splitter, one
// character beat at a time, and lets gifs_field_checker judge every field
// result; gives the final verdict
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// beats of the random part, beyond the directed strings
	localparam int RANDOM_ITEMS   = 220;
	// cycles without any accepted beat before the run is given up
	localparam int WATCHDOG_LIMIT = 1000;
	// settle time after the last owed result
	localparam int DRAIN_CYCLES   = 16;

	typedef enum int {
		RX_OPEN,
		RX_FEW_STALLS,
		RX_MANY_STALLS,
		RX_PATTERN
	} rx_mode_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic [7:0]                    char_code = 8'h00;
	logic                          end_mark  = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [gifs_pkg::FLD_W-1:0]    field_number;
	logic [gifs_pkg::OFS_W-1:0]    start_offset;
	logic [gifs_pkg::OFS_W-1:0]    field_length;
	logic                          present;
	logic                          status;
	logic                          last;
	int unsigned                   mismatches;
	int unsigned                   fields_pending;

	// sender bookkeeping
	int unsigned                   beats_sent = 0;
	int                            burst_left = 0;
	// characters of the string being built, sent in order then closed
	logic [7:0]                    line_buf[$];
	string                         gps_tag = "+CGPSINFO:";

	// receiver stall pattern
	rx_mode_t                      rx_mode      = RX_OPEN;
	int                            rx_mode_left = 0;
	logic [7:0]                    ready_ring   = 8'hFF;

	always #2 clk = ~clk;

	gps_info_field_splitter_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.end_mark     (end_mark),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.field_number (field_number),
		.start_offset (start_offset),
		.field_length (field_length),
		.present      (present),
		.status       (status),
		.last         (last)
	);

	gifs_field_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.char_code      (char_code),
		.end_mark       (end_mark),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.field_number   (field_number),
		.start_offset   (start_offset),
		.field_length   (field_length),
		.present        (present),
		.status         (status),
		.last           (last),
		.mismatches     (mismatches),
		.fields_pending (fields_pending)
	);

	// receiver: a mode is held for a random stretch, from never stalling
	// through random stalls to a rotating ready pattern
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(16, 128);
				ready_ring   = 8'($urandom_range(1, 255));
			end
			rx_mode_left--;
			case (rx_mode)
				RX_OPEN:        out_ready <= 1'b1;
				RX_FEW_STALLS:  out_ready <= ($urandom_range(0, 3) != 0);
				RX_MANY_STALLS: out_ready <= ($urandom_range(0, 3) == 0);
				default: begin
					out_ready <= ready_ring[0];
					ready_ring = {ready_ring[0], ready_ring[7:1]};
				end
			endcase
		end
	end

	// watchdog: give up after a long stretch with no beat moving on either side
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// one character beat; the sender runs in bursts with random gaps between
	// them, long bursts give stretches with no idling at all
	task automatic send_beat(input logic [7:0] ch, input logic em);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 16);
			gap        = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid  <= 1'b1;
		char_code <= ch;
		end_mark  <= em;
		// valid holds with a steady payload until the beat is taken
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	// send the built string, then the end-of-string beat with a junk character
	task automatic send_line();
		int i;
		for (i = 0; i < line_buf.size(); i++)
			send_beat(line_buf[i], 1'b0);
		send_beat(8'($urandom_range(0, 255)), 1'b1);
		line_buf.delete();
	endtask

	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	// leading part of the prefix, cut characters long
	task automatic add_tag_part(input int cut);
		int i;
		for (i = 0; i < cut; i++)
			line_buf.push_back(gps_tag[i]);
	endtask

	// arbitrary bytes: every bit of char_code, commas and plus signs included
	task automatic add_noise(input int n);
		repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	// field text: mostly what a receiver reports, now and then any byte
	task automatic add_field_text(input int n);
		string alpha;
		alpha = "0123456789.-NSEW";
		repeat (n) begin
			if ($urandom_range(0, 7) == 0)
				line_buf.push_back(8'($urandom_range(0, 255)));
			else
				line_buf.push_back(alpha[$urandom_range(0, alpha.len() - 1)]);
		end
	endtask

	// well-formed response: optional junk or echo in front, the prefix, a few
	// spaces, then a random number of fields around the nominal nine
	task automatic build_report_line();
		int n_fields;
		int k;
		case ($urandom_range(0, 4))
			0: add_noise($urandom_range(1, 6));
			// partial prefix, the '+' of the real one restarts the match
			1: add_tag_part($urandom_range(1, 9));
			2: add_text("AT+CGPSINFO\r\n");
			default: ;
		endcase
		add_text(gps_tag);
		repeat ($urandom_range(0, 3)) add_text(" ");
		case ($urandom_range(0, 3))
			0, 1: n_fields = 9;
			// prefix with no field text behind it, only spaces and the optional tail
			2: n_fields = 0;
			default: n_fields = $urandom_range(1, 12);
		endcase
		for (k = 0; k < n_fields; k++) begin
			if (k != 0)
				add_text(",");
			add_field_text($urandom_range(0, 4));
		end
		if ($urandom_range(0, 3) == 0)
			add_text(",");
		if ($urandom_range(0, 5) == 0)
			add_text("\r\nOK\r\n");
	endtask

	// broken prefix, half the time followed by a real one
	task automatic build_broken_line();
		add_tag_part($urandom_range(1, 9));
		add_noise(1);
		add_noise($urandom_range(0, 4));
		add_text(",1,2");
		if ($urandom_range(0, 1) == 0) begin
			add_text(gps_tag);
			add_field_text($urandom_range(0, 4));
			add_text(",");
			add_field_text($urandom_range(0, 4));
		end
	endtask

	initial begin : stimulus
		int unsigned random_from;
		int          kind;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: terminator alone, prefix never seen
		send_line();
		// double plus, space skip, empty fields sent at once, final field
		// frozen by its comma, trailing text after it ignored
		add_text("++CGPSINFO: 7,,,,,,,,b,c");
		send_line();

		// random strings, mostly well-formed with random content
		random_from = beats_sent;
		while (beats_sent < random_from + RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind == 0)
				add_noise($urandom_range(0, 12));
			else if (kind == 1)
				build_broken_line();
			else
				build_report_line();
			send_line();
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (fields_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/gifs_pkg.sv
src/gifs_parse.sv
src/gifs_out_buf.sv
src/gps_info_field_splitter_unit.sv
bench/gifs_field_checker.sv
bench/tb_top.sv
